@@ rtl/sflg_pkg.sv @@
// Package for the stereo flanger: FSM state type, constants and the sine table function.
// No dependencies.
`timescale 1ns / 1ps
package sflg_pkg;

   localparam int PhaseBits = 24;
   localparam int ParamBits = 19;
   localparam int GainBits = 15;
   localparam int SineBits = 16;
   localparam logic [GainBits-1:0] FeedbackLimit = 15'd29491;

   // Register indexes on the configuration port.
   localparam logic [2:0] RegLfoStep = 3'd0;
   localparam logic [2:0] RegDepthLeft = 3'd1;
   localparam logic [2:0] RegDepthRight = 3'd2;
   localparam logic [2:0] RegBaseLeft = 3'd3;
   localparam logic [2:0] RegBaseRight = 3'd4;
   localparam logic [2:0] RegPhaseOffset = 3'd5;
   localparam logic [2:0] RegFeedback = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PHASE,
      ST_SINE,
      ST_DELAY,
      ST_READ_A,
      ST_READ_B,
      ST_INTERP,
      ST_FEEDBACK,
      ST_WRITE,
      ST_NEXT,
      ST_OUTPUT
   } state_type;

   // Sine of a table position in Q1.15, built from a quarter-wave series.
   // The arguments are constant table positions, so the whole evaluation is
   // folded into a constant table at elaboration.
   function automatic logic signed [SineBits-1:0] sine_value(input int unsigned k,
                                                           input int unsigned entries);
      logic [63:0] pos;
      logic [63:0] r;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [1:0] quad;
      logic [63:0] v;
      pos = (64'(k) << 24) / 64'(entries);
      quad = pos[23:22];
      r = pos & 64'h3F_FFFF;
      if (quad[0]) r = 64'h40_0000 - r;
      a = ((r << 8) * 64'd1686629713) >> 30;
      a2 = (a * a) >> 30;
      term = a;
      sum = a;
      for (int n = 1; n <= 4; n++) begin
         term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      v = (sum + 64'd16384) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      if (quad[1]) return -SineBits'(v);
      return SineBits'(v);
   endfunction

endpackage

@@ rtl/sflg_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module sflg_ram #(
   parameter int Width = 24,
   parameter int Depth = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // One access per cycle: write, or read with a registered result.
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end

endmodule

@@ rtl/stereo_flanger_core.sv @@
// Stereo flanger top level: sequencer, datapath and the two delay-line memories.
// Depends on sflg_pkg and sflg_ram.
//
// Usage: one stereo pair enters on the req_ channel (tdata: sample_left in the
// low bits, sample_right above) and one wet pair leaves on the rsp_ channel in
// the same packing. Configuration is written through csr_wr_en/csr_index/csr_data
// while the block is idle; indexes beyond the register list are ignored.
// For each word the two channels are worked through one after the other on a
// shared datapath, and each needs two reads and one write of its delay-line
// memory, one access a cycle.
// A new word is accepted only once the last one has moved to the output register.
// The result sits in an output register; the next word is accepted while that
// result still waits, and its own result is held in the final step until the
// register is taken, so a stalled receiver holds the block after one more word.
// After reset a clearing pass writes zero to every delay-line entry, during
// which no word is accepted.
`timescale 1ns / 1ps
module stereo_flanger_core
   import sflg_pkg::*;
#(
   parameter int LineDepth = 2048,
   parameter int SampleBits = 24,
   parameter int SineEntries = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // sample_left, sample_right
   input  logic [2*SampleBits-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // wet_left, wet_right
   output logic [2*SampleBits-1:0] rsp_tdata,
   input  logic                    csr_wr_en,
   input  logic [2:0]              csr_index,
   input  logic [PhaseBits-1:0]    csr_data
);

   localparam int AddrBits = $clog2(LineDepth);
   localparam int SineIdxBits = $clog2(SineEntries);
   localparam int PosBits = AddrBits + 8;
   localparam int DelayBits = (ParamBits + 1 > PosBits) ? ParamBits + 1 : PosBits;
   localparam logic [DelayBits-1:0] DelayMax = DelayBits'(LineDepth - 1) << 8;
   localparam logic [AddrBits-1:0] LastAddr = AddrBits'(LineDepth - 1);
   localparam logic signed [SampleBits+1:0] SampleMax = (SampleBits+2)'((1 << (SampleBits-1)) - 1);
   localparam logic signed [SampleBits+1:0] SampleMin = -SampleMax - 1;

   // Sine table as a constant array.
   logic signed [SineBits-1:0] sine_rom [SineEntries];
   for (genvar g = 0; g < SineEntries; g++) begin : g_rom
      assign sine_rom[g] = sine_value(g, SineEntries);
   end

   // Configuration registers.
   logic [PhaseBits-1:0] lfo_step_ff, phase_offset_ff;
   logic [ParamBits-1:0] depth_l_ff, depth_r_ff, base_l_ff, base_r_ff;
   logic [GainBits-1:0]  gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lfo_step_ff <= PhaseBits'(1);
         phase_offset_ff <= '0;
         depth_l_ff <= '0;
         depth_r_ff <= '0;
         base_l_ff <= ParamBits'(24576);
         base_r_ff <= ParamBits'(24576);
         gain_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            RegLfoStep: lfo_step_ff <= csr_data;
            RegDepthLeft: depth_l_ff <= csr_data[ParamBits-1:0];
            RegDepthRight: depth_r_ff <= csr_data[ParamBits-1:0];
            RegBaseLeft: base_l_ff <= csr_data[ParamBits-1:0];
            RegBaseRight: base_r_ff <= csr_data[ParamBits-1:0];
            RegPhaseOffset: phase_offset_ff <= csr_data;
            RegFeedback: gain_ff <= csr_data[GainBits-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer and datapath registers.
   state_type state_ff, state_in;
   logic side_ff;                          // 0 left, 1 right
   logic [AddrBits-1:0] clr_ff;
   logic [AddrBits-1:0] widx_ff;
   logic [PhaseBits-1:0] phase_ff;
   logic signed [SampleBits-1:0] in_l_ff, in_r_ff;
   logic signed [SineBits-1:0] sin_ff;
   logic [DelayBits-1:0] delay_ff;
   logic [AddrBits-1:0] idx_ff;
   logic [7:0] frac_ff;
   logic signed [SampleBits-1:0] a_ff;
   logic signed [SampleBits-1:0] wet_ff;
   logic signed [SampleBits-1:0] wet_l_ff;
   logic signed [SampleBits+1:0] out_ff;
   logic [2*SampleBits-1:0] rsp_data_ff;
   logic rsp_valid_ff;
   logic out_load;

   logic [PhaseBits-1:0] cur_phase;
   logic [ParamBits-1:0] cur_depth, cur_base;
   logic signed [SampleBits-1:0] cur_in;
   logic [GainBits-1:0] gain_sat;
   logic [SineBits:0] u_val;
   logic [ParamBits+SineBits:0] u_prod;
   logic [DelayBits-1:0] delay_sum, delay_clamp;
   logic [PosBits-1:0] pos;
   logic signed [SampleBits+9:0] interp;
   logic signed [SampleBits+GainBits+1:0] fb_prod;
   logic signed [SampleBits+1:0] sub_val;

   assign cur_phase = side_ff ? phase_ff + phase_offset_ff : phase_ff;
   assign cur_depth = side_ff ? depth_r_ff : depth_l_ff;
   assign cur_base = side_ff ? base_r_ff : base_l_ff;
   assign cur_in = side_ff ? in_r_ff : in_l_ff;
   assign gain_sat = (gain_ff > FeedbackLimit) ? FeedbackLimit : gain_ff;

   // Delay from the sine value: one multiply, then clamp.
   assign u_val = (SineBits+1)'($signed(sin_ff) + 32768);
   assign u_prod = u_val * cur_depth;
   assign delay_sum = DelayBits'(cur_base) + DelayBits'(u_prod >> 16);
   assign delay_clamp = (delay_sum > DelayMax) ? DelayMax : delay_sum;
   assign pos = {widx_ff, 8'd0} - delay_ff[PosBits-1:0];

   // Interpolation of the two neighbours, rounded.
   logic signed [SampleBits-1:0] b_val;
   assign interp = $signed({{10{a_ff[SampleBits-1]}}, a_ff}) * $signed({1'b0, 9'(256 - frac_ff)})
                 + $signed({{10{b_val[SampleBits-1]}}, b_val}) * $signed({2'b0, frac_ff})
                 + (SampleBits+10)'(128);
   assign fb_prod = $signed({{(GainBits+2){wet_ff[SampleBits-1]}}, wet_ff})
                  * $signed({{(SampleBits+2){1'b0}}, gain_sat}) + (SampleBits+GainBits+2)'(16384);
   assign sub_val = (SampleBits+2)'(cur_in) - (SampleBits+2)'(fb_prod >>> 15);

   // Memory port control.
   logic ram_we;
   logic [AddrBits-1:0] ram_addr;
   logic [SampleBits-1:0] ram_wdata, rd_l, rd_r;
   logic we_l, we_r;
   logic signed [SampleBits-1:0] rd_cur;

   assign rd_cur = side_ff ? rd_r : rd_l;
   assign b_val = rd_cur;
   assign we_l = ram_we && (state_ff == ST_CLEAR || !side_ff);
   assign we_r = ram_we && (state_ff == ST_CLEAR || side_ff);

   sflg_ram #(.Width(SampleBits), .Depth(LineDepth)) u_line_left (
      .clock(clock), .wr_en(we_l), .addr(ram_addr), .wr_data(ram_wdata), .rd_data(rd_l));
   sflg_ram #(.Width(SampleBits), .Depth(LineDepth)) u_line_right (
      .clock(clock), .wr_en(we_r), .addr(ram_addr), .wr_data(ram_wdata), .rd_data(rd_r));

   // The finished pair moves to the output register once that register is free.
   assign out_load = (state_ff == ST_OUTPUT) && (!rsp_valid_ff || rsp_tready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == LastAddr) state_in = ST_IDLE;
         ST_IDLE: if (req_tvalid) state_in = ST_PHASE;
         ST_PHASE: state_in = ST_SINE;
         ST_SINE: state_in = ST_DELAY;
         ST_DELAY: state_in = ST_READ_A;
         ST_READ_A: state_in = ST_READ_B;
         ST_READ_B: state_in = ST_INTERP;
         ST_INTERP: state_in = ST_FEEDBACK;
         ST_FEEDBACK: state_in = ST_WRITE;
         ST_WRITE: state_in = side_ff ? ST_OUTPUT : ST_NEXT;
         ST_NEXT: state_in = ST_SINE;
         ST_OUTPUT: if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      ram_we = 1'b0;
      ram_addr = idx_ff;
      ram_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = clr_ff;
         end
         ST_READ_A: ram_addr = pos[PosBits-1:8];
         ST_READ_B: ram_addr = (idx_ff == LastAddr) ? '0 : idx_ff + 1'b1;
         ST_WRITE: begin
            ram_we = 1'b1;
            ram_addr = widx_ff;
            ram_wdata = out_ff[SampleBits-1:0];
         end
         default: ;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         widx_ff <= '0;
         phase_ff <= '0;
         side_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         // Output register: load a finished pair, or drop a word once it is taken.
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff <= {wet_ff, wet_l_ff};
            widx_ff <= (widx_ff == LastAddr) ? '0 : widx_ff + 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               in_l_ff <= req_tdata[SampleBits-1:0];
               in_r_ff <= req_tdata[2*SampleBits-1:SampleBits];
               side_ff <= 1'b0;
            end
            ST_PHASE: phase_ff <= phase_ff + lfo_step_ff;
            ST_SINE: sin_ff <= sine_rom[cur_phase[PhaseBits-1 -: SineIdxBits]];
            ST_DELAY: delay_ff <= delay_clamp;
            ST_READ_A: begin
               idx_ff <= pos[PosBits-1:8];
               frac_ff <= pos[7:0];
            end
            ST_READ_B: a_ff <= rd_cur;
            ST_INTERP: wet_ff <= interp[SampleBits+7:8];
            ST_FEEDBACK:
               out_ff <= (sub_val > SampleMax) ? SampleMax :
                         (sub_val < SampleMin) ? SampleMin : sub_val;
            ST_WRITE: if (!side_ff) wet_l_ff <= wet_ff;
            ST_NEXT: side_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // The clearing pass and an item never overlap.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready) else $error("accept during clear");
   // A result is raised only from the final sequencer step.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUTPUT) else $error("stray result");
   // The write index moves once per item.
   a_widx_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(widx_ff) |-> $past(state_ff) == ST_OUTPUT) else $error("index slip");

endmodule

@@ verif/stereo_flanger_checker.sv @@
// Checker for the stereo flanger: watches the request, response and register ports,
// predicts each wet pair from its own model of the delay lines, and counts mismatches.
// Depends on sflg_pkg for the register indexes and the feedback limit.
`timescale 1ns / 1ps
module stereo_flanger_checker
   import sflg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // sample_left, sample_right
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // wet_left, wet_right
   input  logic [47:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   output int          mismatches,
   output int          outstanding
);

   localparam int Depth = 2048;
   localparam int Entries = 1024;
   localparam longint SampleMax = 64'sd8388607;
   localparam longint SampleMin = -64'sd8388608;

   // Register copies.
   logic [23:0] step_reg, offset_reg;
   logic [18:0] depth_reg [2];
   logic [18:0] base_reg [2];
   logic [14:0] gain_reg;

   // Delay-line copies and sequencing state.
   int          lines [2][Depth];
   logic [10:0] wr_ptr;
   logic [23:0] phase_acc;
   int          sine_tab [Entries];

   logic [47:0] wet_queue [$];

   // Quarter-wave series evaluated once into a table, Q1.15.
   initial begin
      longint unsigned pos, r, a, a2, term, sum;
      int quad;
      for (int k = 0; k < Entries; k++) begin
         pos = (longint'(k) << 24) / Entries;
         quad = int'((pos >> 22) & 3);
         r = pos & 64'h3F_FFFF;
         if (quad % 2 == 1) r = 64'h40_0000 - r;
         a = ((r << 8) * 64'd1686629713) >> 30;
         a2 = (a * a) >> 30;
         term = a;
         sum = a;
         for (int n = 1; n <= 4; n++) begin
            term = ((term * a2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         sum = (sum + 64'd16384) >> 15;
         if (sum > 32767) sum = 32767;
         sine_tab[k] = (quad >= 2) ? -int'(sum) : int'(sum);
      end
   end

   // One channel: interpolated read at the modulated delay, then the feedback write.
   function automatic logic [23:0] delay_tap(input int ch, input logic [23:0] phase,
                                             input logic [23:0] sample, input longint gain);
      longint unsigned u, dly, pos, idx, nxt, frac;
      longint wet, res;
      u = longint'(sine_tab[phase[23:14]] + 32768);
      dly = longint'(base_reg[ch]) + ((u * longint'(depth_reg[ch])) >> 16);
      if (dly > longint'(Depth - 1) * 256) dly = longint'(Depth - 1) * 256;
      pos = ((longint'(wr_ptr) << 8) + longint'(Depth) * 256 - dly) % (longint'(Depth) * 256);
      idx = pos >> 8;
      frac = pos & 255;
      nxt = (idx + 1) % Depth;
      wet = (longint'(lines[ch][idx]) * longint'(256 - frac)
             + longint'(lines[ch][nxt]) * longint'(frac) + 128) >>> 8;
      res = longint'($signed(sample)) - ((gain * wet + 16384) >>> 15);
      if (res > SampleMax) res = SampleMax;
      if (res < SampleMin) res = SampleMin;
      lines[ch][wr_ptr] = int'(res);
      return wet[23:0];
   endfunction

   assign outstanding = wet_queue.size();

   always @(posedge clock) begin
      logic [23:0] right_phase, wet_l, wet_r;
      logic [47:0] want;
      longint gain;
      if (reset) begin
         step_reg <= 24'd1;
         offset_reg <= '0;
         depth_reg[0] <= '0;
         depth_reg[1] <= '0;
         base_reg[0] <= 19'd24576;
         base_reg[1] <= 19'd24576;
         gain_reg <= '0;
         wr_ptr <= '0;
         phase_acc <= '0;
         mismatches <= 0;
         wet_queue.delete();
         for (int i = 0; i < Depth; i++) begin
            lines[0][i] = 0;
            lines[1][i] = 0;
         end
      end else begin
         // Register writes; an unlisted index changes nothing.
         if (csr_wr_en) begin
            case (csr_index)
               RegLfoStep: step_reg <= csr_data;
               RegDepthLeft: depth_reg[0] <= csr_data[18:0];
               RegDepthRight: depth_reg[1] <= csr_data[18:0];
               RegBaseLeft: base_reg[0] <= csr_data[18:0];
               RegBaseRight: base_reg[1] <= csr_data[18:0];
               RegPhaseOffset: offset_reg <= csr_data;
               RegFeedback: gain_reg <= csr_data[14:0];
               default: ;
            endcase
         end
         // Each accepted word yields one expected wet pair.
         if (req_tvalid && req_tready) begin
            gain = (gain_reg > FeedbackLimit) ? longint'(FeedbackLimit) : longint'(gain_reg);
            right_phase = phase_acc + step_reg + offset_reg;
            wet_l = delay_tap(0, phase_acc + step_reg, req_tdata[23:0], gain);
            wet_r = delay_tap(1, right_phase, req_tdata[47:24], gain);
            phase_acc <= phase_acc + step_reg;
            wr_ptr <= wr_ptr + 11'd1;
            wet_queue.push_back({wet_r, wet_l});
         end
         // Compare each response word with the oldest expectation.
         if (rsp_tvalid && rsp_tready) begin
            if (wet_queue.size() == 0) begin
               if (mismatches < 10) $display("unexpected response word %h", rsp_tdata);
               mismatches <= mismatches + 1;
            end else begin
               want = wet_queue.pop_front();
               if (want != rsp_tdata) begin
                  if (mismatches < 10)
                     $display("wet mismatch: left exp %h got %h, right exp %h got %h",
                              want[23:0], rsp_tdata[23:0], want[47:24], rsp_tdata[47:24]);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

@@ verif/stereo_flanger_core_test.sv @@
// Top of the stereo flanger testbench: clock, reset, register settings and stimulus.
// Depends on sflg_pkg, stereo_flanger_core and stereo_flanger_checker.
`timescale 1ns / 1ps
module stereo_flanger_core_test
   import sflg_pkg::*;
();

   localparam logic [2:0] RegUnlisted = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;
   int          mismatches;
   int          outstanding;
   int          send_idle = 35;
   int          recv_idle = 63;

   always #4 clock = ~clock;

   stereo_flanger_core DUT (.*);

   stereo_flanger_checker checker_i (.*);

   // Receiver stalls at random.
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle);

   // Offer one word, with a random gap before it, and wait until it is taken.
   task automatic send_word(input logic [23:0] left, input logic [23:0] right);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {right, left};
      do @(posedge clock); while (!req_tready);
   endtask

   // Writes every register in turn, plus an unlisted index that must be ignored.
   task automatic write_regs(input logic [23:0] vals [7]);
      logic [2:0] idx [7];
      idx = '{RegLfoStep, RegDepthLeft, RegDepthRight, RegBaseLeft, RegBaseRight,
              RegPhaseOffset, RegFeedback};
      for (int i = 0; i < 7; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_index <= RegUnlisted;
      csr_data <= 24'($urandom());
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Extremes often, small values sometimes, otherwise the full range.
   function automatic logic [23:0] pick_sample();
      case ($urandom_range(7))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'($signed($urandom_range(512)) - 256);
         default: return 24'($urandom());
      endcase
   endfunction

   initial begin
      logic [23:0] vals [7];
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // The block clears its delay lines after reset.
      repeat (2100) @(posedge clock);
      for (int s = 0; s < 9; s++) begin
         if (s == 3) begin
            send_idle = 63;
            recv_idle = 35;
         end else if (s == 6) begin
            send_idle = 0;
            recv_idle = 0;
         end
         case (s)
            0: vals = '{24'd1, 24'd0, 24'd0, 24'd24576, 24'd24576, 24'd0, 24'd0};
            // Longest delays clamp; gain above the limit saturates.
            1: vals = '{24'hFFFFFF, 24'h7FFFF, 24'h7FFFF, 24'h7FFFF, 24'h7FFFF,
                        24'hFFFFFF, 24'h7FFF};
            // Zero delay reads the slot before it is overwritten.
            2: vals = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
            // Sub-sample delays swinging across one sample.
            3: vals = '{24'h012345, 24'd200, 24'd300, 24'd100, 24'd40, 24'h800000,
                        24'd29491};
            default: vals = '{24'($urandom()), 24'($urandom_range(19'h7FFFF)),
                              24'($urandom_range(19'h7FFFF)), 24'($urandom_range(19'h40000)),
                              24'($urandom_range(19'h1000)), 24'($urandom()),
                              24'($urandom_range(15'h7FFF))};
         endcase
         write_regs(vals);
         if (s == 0) begin
            // Directed extremes of both channels.
            send_word(24'h7FFFFF, 24'h800000);
            send_word(24'h800000, 24'h7FFFFF);
            send_word(24'h000000, 24'hFFFFFF);
            send_word(24'hFFFFFF, 24'h000000);
            send_word(24'h555555, 24'hAAAAAA);
            send_word(24'hAAAAAA, 24'h555555);
            send_word(24'h000001, 24'h7FFFFE);
         end
         repeat (s == 0 ? 88 : 95) send_word(pick_sample(), pick_sample());
         req_tvalid <= 1'b0;
         // Let the block drain before the next settings.
         do @(posedge clock); while (outstanding != 0);
         repeat (24) @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

@@ files.f @@
rtl/sflg_pkg.sv
rtl/sflg_ram.sv
rtl/stereo_flanger_core.sv
verif/stereo_flanger_checker.sv
verif/stereo_flanger_core_test.sv
